[rtl/core/pts_pkg.sv]
// Package for the priority task scheduler: sizes, command codes and slot state codes.
// Depends on nothing; the scheduler top level and the bench import it.
package pts_pkg;

    localparam int NUM_TASKS     = 8;
    localparam int TIMEOUT_WIDTH = 32;
    localparam int SLOT_W        = $clog2(NUM_TASKS);
    localparam int ENTRY_W       = 2 + TIMEOUT_WIDTH;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SLEEP = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef logic [1:0] slot_state_t;

    localparam slot_state_t SLOT_EMPTY = 2'd0;
    localparam slot_state_t SLOT_READY = 2'd1;
    localparam slot_state_t SLOT_WAIT  = 2'd2;

endpackage

[rtl/core/pts_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Uses no package; the scheduler keeps its slot table in one instance.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/priority_task_scheduler.sv]
// Top level of the fixed-priority task scheduler with sleep timeouts.
// Depends on pts_pkg and on pts_ram, which holds the state and timeout of every slot.

// Each input word carries a command. An add writes its slot on acceptance and puts its
// result in the output register from the done state. A tick, or a sleep while a task runs,
// scans the slot table from the highest added slot down, one slot per cycle through the
// single read port of the slot RAM, and scans at most NUM_TASKS - 1 slots. One word is
// worked on at a time; a new word is accepted while the last result still waits in the
// output register. After reset every slot reads as empty through per-slot valid flags,
// so no clearing pass is needed.
module priority_task_scheduler
    import pts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input word, from bit 0: task_id[2:0], sleep_time[34:3], zero fill.
    input  logic [39:0] s_axis_tdata,
    // Input kind, from bit 0: cmd[1:0].
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Result word, from bit 0: chosen_task[2:0], switch_request[3], zero fill.
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic [SLOT_W-1:0]      top_slot_reg, top_slot_next;
    logic [SLOT_W-1:0]      running_reg, running_next;
    logic                   running_valid_reg, running_valid_next;
    logic [NUM_TASKS-1:0]   valid_reg, valid_next;
    logic [SLOT_W-1:0]      res_task_reg, res_task_next;
    logic                   res_sw_reg, res_sw_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]      m_task_reg, m_task_next;
    logic                   m_sw_reg, m_sw_next;

    logic                   ram_we, ram_re;
    logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

    logic [1:0]             in_cmd;
    logic [2:0]             in_task_id;
    logic [31:0]            in_sleep_time;
    logic                   in_accept;
    logic                   add_ok;
    logic [SLOT_W-1:0]      add_slot;

    logic [ENTRY_W-1:0]     entry;
    slot_state_t            entry_state;
    logic [TIMEOUT_WIDTH-1:0] entry_time, time_dec;
    logic                   slot_ready;
    logic                   do_pick;
    logic [SLOT_W-1:0]      pick_slot;

    assign in_cmd        = s_axis_tuser;
    assign in_task_id    = s_axis_tdata[2:0];
    assign in_sleep_time = s_axis_tdata[34:3];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign add_ok        = 32'(in_task_id) < 32'(NUM_TASKS);
    assign add_slot      = SLOT_W'(32'(in_task_id));

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_sw_reg, 3'(m_task_reg)};

    // A slot never written since reset reads as empty with a zero timeout.
    assign entry       = valid_reg[scan_reg] ? ram_rdata : '0;
    assign entry_state = entry[ENTRY_W-1:TIMEOUT_WIDTH];
    assign entry_time  = entry[TIMEOUT_WIDTH-1:0];
    assign time_dec    = entry_time - 1'b1;

    pts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_TASKS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next         = state_reg;
        scan_next          = scan_reg;
        top_slot_next      = top_slot_reg;
        running_next       = running_reg;
        running_valid_next = running_valid_reg;
        valid_next         = valid_reg;
        res_task_next      = res_task_reg;
        res_sw_next        = res_sw_reg;
        m_valid_next       = m_valid_reg && !m_axis_tready;
        m_task_next        = m_task_reg;
        m_sw_next          = m_sw_reg;
        ram_we             = 1'b0;
        ram_waddr          = scan_reg;
        ram_wdata          = '0;
        ram_re             = 1'b0;
        ram_raddr          = scan_reg;
        slot_ready         = 1'b0;
        do_pick            = 1'b0;
        pick_slot          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    // Commands that do not schedule report the running task, no switch.
                    res_task_next = running_reg;
                    res_sw_next   = 1'b0;
                    scan_next     = top_slot_reg;
                    state_next    = ST_DONE;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (add_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = add_slot;
                                ram_wdata = {SLOT_READY, {TIMEOUT_WIDTH{1'b0}}};
                                valid_next[add_slot] = 1'b1;
                                if (add_slot > top_slot_reg) begin
                                    top_slot_next = add_slot;
                                end
                            end
                        end
                        CMD_SLEEP: begin
                            if (running_valid_reg) begin
                                ram_we    = 1'b1;
                                ram_waddr = running_reg;
                                ram_wdata = {SLOT_WAIT, in_sleep_time[TIMEOUT_WIDTH-1:0]};
                                valid_next[running_reg] = 1'b1;
                                state_next = ST_START;
                            end
                        end
                        CMD_TICK: begin
                            state_next = ST_START;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_START: begin
                if (scan_reg == '0) begin
                    do_pick = 1'b1;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (entry_state == SLOT_WAIT) begin
                    ram_we     = 1'b1;
                    ram_waddr  = scan_reg;
                    slot_ready = (time_dec == '0);
                    ram_wdata  = {slot_ready ? SLOT_READY : SLOT_WAIT, time_dec};
                end else begin
                    slot_ready = (entry_state == SLOT_READY);
                end
                if (slot_ready) begin
                    do_pick   = 1'b1;
                    pick_slot = scan_reg;
                end else if (scan_reg == SLOT_W'(1)) begin
                    do_pick = 1'b1;
                end else begin
                    // Next slot down is read while this one, if waiting, is written back.
                    ram_re    = 1'b1;
                    ram_raddr = scan_reg - 1'b1;
                    scan_next = scan_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_task_next  = res_task_reg;
                    m_sw_next    = res_sw_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_pick) begin
            res_task_next      = pick_slot;
            res_sw_next        = !running_valid_reg || (running_reg != pick_slot);
            running_next       = pick_slot;
            running_valid_next = 1'b1;
            state_next         = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            scan_reg          <= '0;
            top_slot_reg      <= '0;
            running_reg       <= '0;
            running_valid_reg <= 1'b0;
            valid_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            scan_reg          <= scan_next;
            top_slot_reg      <= top_slot_next;
            running_reg       <= running_next;
            running_valid_reg <= running_valid_next;
            valid_reg         <= valid_next;
            m_valid_reg       <= m_valid_next;
        end
        res_task_reg <= res_task_next;
        res_sw_reg   <= res_sw_next;
        m_task_reg   <= m_task_next;
        m_sw_reg     <= m_sw_next;
    end

    // The scan stays within the added slots and never reaches the idle slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_reg != '0) && (scan_reg <= top_slot_reg))
        else $error("scan index out of range");

    // Write-back and look-ahead read never hit the same slot in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("slot RAM read and write collide");

    // Once a task has been scheduled, some task is always running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_valid_reg |=> running_valid_reg)
        else $error("running flag dropped");

    // A waiting slot is only ever read from a slot that was written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && entry_state == SLOT_WAIT) |-> valid_reg[scan_reg])
        else $error("waiting state read from unwritten slot");

    // An accepted word always ends in the output stage before the next is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_axis_tready)
        else $error("input accepted twice without a result");

endmodule

[bench/priority_task_scheduler_test.sv]
// Self-checking bench for priority_task_scheduler: random and directed command words,
// a cycle-free predictor of the slot table, and random stalls on both stream sides.
// Depends on pts_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module priority_task_scheduler_test;
    import pts_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [1:0]               cmd;
        logic [SLOT_W-1:0]        slot;
        logic [TIMEOUT_WIDTH-1:0] wait_time;
    } sched_cmd_t;

    typedef struct {
        logic [SLOT_W-1:0] chosen;
        logic              switched;
    } dispatch_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    priority_task_scheduler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of the slot table and the running task.
    slot_state_t              tbl_state   [NUM_TASKS] = '{default: SLOT_EMPTY};
    logic [TIMEOUT_WIDTH-1:0] tbl_timeout [NUM_TASKS] = '{default: '0};
    logic [SLOT_W-1:0]        top_added = '0;
    logic [SLOT_W-1:0]        cur_slot = '0;
    logic                     cur_valid = 1'b0;

    sched_cmd_t cmd_backlog[$];
    sched_cmd_t cmd_in_flight;
    dispatch_t  expected_dispatch[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         fail_count = 0;

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    // Scan from the highest added slot down to 1; waiting slots that are passed count
    // down and wake at zero. The first ready slot wins, otherwise the idle slot.
    function automatic dispatch_t schedule_slots();
        dispatch_t         r;
        logic [SLOT_W-1:0] s;
        s = top_added;
        while (s != '0) begin
            if (tbl_state[s] == SLOT_WAIT) begin
                tbl_timeout[s] = tbl_timeout[s] - 1'b1;
                if (tbl_timeout[s] == '0)
                    tbl_state[s] = SLOT_READY;
            end
            if (tbl_state[s] == SLOT_READY)
                break;
            s = s - 1'b1;
        end
        r.chosen   = s;
        r.switched = !cur_valid || (cur_slot != s);
        cur_slot   = s;
        cur_valid  = 1'b1;
        return r;
    endfunction

    function automatic dispatch_t predict_dispatch(input sched_cmd_t c);
        dispatch_t r;
        r.chosen   = cur_slot;
        r.switched = 1'b0;
        case (c.cmd)
            CMD_ADD: begin
                if (c.slot > top_added)
                    top_added = c.slot;
                tbl_timeout[c.slot] = '0;
                tbl_state[c.slot]   = SLOT_READY;
            end
            CMD_SLEEP: begin
                if (cur_valid) begin
                    tbl_state[cur_slot]   = SLOT_WAIT;
                    tbl_timeout[cur_slot] = c.wait_time;
                    r = schedule_slots();
                end
            end
            CMD_TICK: begin
                r = schedule_slots();
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input int slot,
                             input logic [TIMEOUT_WIDTH-1:0] wait_time);
        sched_cmd_t c;
        c.cmd       = cmd;
        c.slot      = slot[SLOT_W-1:0];
        c.wait_time = wait_time;
        cmd_backlog.push_back(c);
    endtask

    // Mostly short sleeps so tasks wake up again; zero and huge times park a task
    // until it is added again.
    task automatic queue_random(input int count);
        int                       pick;
        int                       sel;
        logic [1:0]               cmd;
        logic [TIMEOUT_WIDTH-1:0] t;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                cmd = CMD_ADD;
            else if (pick < 60)
                cmd = CMD_SLEEP;
            else if (pick < 95)
                cmd = CMD_TICK;
            else
                cmd = CMD_UNUSED;
            sel = $urandom_range(19);
            if (sel == 0)
                t = '0;
            else if (sel == 1)
                t = '1;
            else if (sel < 4)
                t = $urandom();
            else
                t = $urandom_range(12, 1);
            queue_cmd(cmd, $urandom_range(NUM_TASKS - 1), t);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_axis_tvalid || expected_dispatch.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: a word stays on the bus until it is taken; the prediction is made at
    // the edge where it is accepted.
    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_dispatch.push_back(predict_dispatch(cmd_in_flight));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_in_flight = cmd_backlog.pop_front();
                    s_axis_tdata  <= {5'b00000, cmd_in_flight.wait_time, cmd_in_flight.slot};
                    s_axis_tuser  <= cmd_in_flight.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        dispatch_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dispatch.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing pending",
                                              m_axis_tdata));
                end else begin
                    want = expected_dispatch.pop_front();
                    if (m_axis_tdata[2:0] != want.chosen)
                        report_mismatch($sformatf("chosen_task %0d, predicted %0d",
                                                  m_axis_tdata[2:0], want.chosen));
                    if (m_axis_tdata[3] != want.switched)
                        report_mismatch($sformatf("switch_request %0b, predicted %0b",
                                                  m_axis_tdata[3], want.switched));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Nothing running yet: the sleep is dropped and the unused command does nothing.
        queue_cmd(CMD_SLEEP, 0, 32'd5);
        queue_cmd(CMD_UNUSED, 7, '1);
        // First scheduling with an empty table picks the idle task and switches.
        queue_cmd(CMD_TICK, 0, '0);
        queue_cmd(CMD_TICK, 3, '0);
        // The idle task goes to sleep but still wins.
        queue_cmd(CMD_SLEEP, 0, 32'd3);
        queue_cmd(CMD_ADD, 0, '0);
        queue_cmd(CMD_ADD, 2, '0);
        queue_cmd(CMD_ADD, 5, '0);
        queue_cmd(CMD_ADD, 7, '1);
        queue_cmd(CMD_TICK, 0, '0);
        // A zero sleep wraps on its first count and parks the task.
        queue_cmd(CMD_SLEEP, 0, '0);
        queue_cmd(CMD_SLEEP, 0, 32'd2);
        queue_cmd(CMD_SLEEP, 0, 32'd1);
        queue_cmd(CMD_TICK, 0, '0);
        queue_cmd(CMD_SLEEP, 0, '1);
        queue_cmd(CMD_ADD, 7, '0);
        queue_cmd(CMD_TICK, 0, '0);
        // A task that wakes in the same scan wins again without a switch.
        queue_cmd(CMD_SLEEP, 0, 32'd1);
        queue_cmd(CMD_ADD, 1, '0);
        queue_cmd(CMD_ADD, 3, '0);
        queue_cmd(CMD_ADD, 4, '0);
        queue_cmd(CMD_ADD, 6, '0);
        queue_cmd(CMD_TICK, 0, '0);
        queue_random(375);
        wait_drained();

        send_idle_pct = 66;
        queue_random(375);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 66;
        queue_random(375);
        wait_drained();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        queue_random(375);
        wait_drained();

        repeat (16) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
